// ===== rtl/cppi_pkg.sv =====
`timescale 1ns / 1ps

package cppi_pkg;

  // Fixed sizes of the block.
  localparam int MAX_LENGTH  = 4096;
  localparam int SAMPLE_BITS = 16;
  localparam int IDX_W       = $clog2(MAX_LENGTH);
  localparam int MOD_W       = 13;
  localparam int CORR_W      = 16;
  localparam int DEN_W       = SAMPLE_BITS + 1;

  // The correction is n * 2^14 / d with n < d, so it has 14 magnitude bits.
  localparam int QUOT_W      = 14;
  localparam int STEP_W      = $clog2(QUOT_W);

  // Register map.
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam logic CFG_IDX_MODULUS = 1'b0;
  localparam logic [MOD_W-1:0] MODULUS_RESET = MOD_W'(1024);
  localparam logic [MOD_W-1:0] MODULUS_MIN   = MOD_W'(3);
  localparam logic [MOD_W-1:0] MODULUS_MAX   = MOD_W'(MAX_LENGTH);

  // Stream widths.
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 32;

  // One peak waiting for its division.
  typedef struct packed {
    logic [IDX_W-1:0]       peak_index;
    logic [SAMPLE_BITS-1:0] num_mag;
    logic [DEN_W-1:0]       den_mag;
    logic                   negative;
  } cppi_job_t;

  // One finished result.
  typedef struct packed {
    logic [CORR_W-1:0] correction;
    logic [IDX_W-1:0]  peak_index;
  } cppi_result_t;

endpackage

// ===== rtl/cppi_front.sv =====
`timescale 1ns / 1ps

module cppi_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [cppi_pkg::MOD_W-1:0]     modulus,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [cppi_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                           job_valid,
  input  logic                           job_ready,
  output cppi_pkg::cppi_job_t            job
);
  import cppi_pkg::*;

  localparam logic [1:0] PRIMED_FULL = 2'd2;

  logic [SAMPLE_BITS-1:0] older_r, older_nxt;
  logic [SAMPLE_BITS-1:0] middle_r, middle_nxt;
  logic [IDX_W-1:0]       wi_r, wi_nxt;
  logic [1:0]             primed_r, primed_nxt;

  logic [MOD_W-1:0]       eff_mod;
  logic [IDX_W-1:0]       cur_idx;
  logic [IDX_W-1:0]       mid_idx;
  logic [MOD_W-1:0]       cur_inc;
  logic                   is_peak;
  logic                   accept;
  logic [DEN_W:0]         den_full;

  // Clamp the modulus into its legal range.
  always_comb begin
    if (modulus < MODULUS_MIN) begin
      eff_mod = MODULUS_MIN;
    end else if (modulus > MODULUS_MAX) begin
      eff_mod = MODULUS_MAX;
    end else begin
      eff_mod = modulus;
    end
  end

  // Circular index of this sample and of the middle one.
  always_comb begin
    cur_idx = ({1'b0, wi_r} < eff_mod) ? wi_r : '0;
    mid_idx = (cur_idx == '0) ? IDX_W'(eff_mod - MOD_W'(1)) : cur_idx - IDX_W'(1);
    cur_inc = {1'b0, cur_idx} + MOD_W'(1);
  end

  // A strict local maximum in the middle once two samples are held.
  assign is_peak = (primed_r == PRIMED_FULL) && (middle_r > older_r) && (middle_r > in_sample);

  // Magnitudes for the divider: |t1 - t2| and 2t - t1 - t2.
  assign den_full = {1'b0, middle_r, 1'b0} - (DEN_W+1)'(older_r) - (DEN_W+1)'(in_sample);

  always_comb begin
    job.peak_index = mid_idx;
    job.negative   = older_r > in_sample;
    job.num_mag    = (older_r >= in_sample) ? older_r - in_sample : in_sample - older_r;
    job.den_mag    = den_full[DEN_W-1:0];
  end

  // Hold off only when no queue slot is free.
  assign in_ready  = job_ready;
  assign accept    = in_valid && in_ready;
  assign job_valid = accept && is_peak;

  // Sample history and index update.
  always_comb begin
    older_nxt  = older_r;
    middle_nxt = middle_r;
    wi_nxt     = wi_r;
    primed_nxt = primed_r;
    if (accept) begin
      older_nxt  = middle_r;
      middle_nxt = in_sample;
      wi_nxt     = (cur_inc >= eff_mod) ? '0 : cur_inc[IDX_W-1:0];
      if (primed_r != PRIMED_FULL) begin
        primed_nxt = primed_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_r  <= '0;
      middle_r <= '0;
      wi_r     <= '0;
      primed_r <= '0;
    end else begin
      older_r  <= older_nxt;
      middle_r <= middle_nxt;
      wi_r     <= wi_nxt;
      primed_r <= primed_nxt;
    end
  end

endmodule

// ===== rtl/cppi_queue.sv =====
`timescale 1ns / 1ps

module cppi_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  cppi_pkg::cppi_job_t push_job,
  output logic                pop_valid,
  input  logic                pop_ready,
  output cppi_pkg::cppi_job_t pop_job
);
  import cppi_pkg::*;

  localparam logic [1:0] DEPTH = 2'd2;

  cppi_job_t  slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count_r != DEPTH);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_job    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== rtl/cppi_back.sv =====
`timescale 1ns / 1ps

module cppi_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   job_valid,
  output logic                   job_ready,
  input  cppi_pkg::cppi_job_t    job,
  output logic                   out_valid,
  input  logic                   out_ready,
  output cppi_pkg::cppi_result_t out_result
);
  import cppi_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUOT_W - 1);

  logic [1:0]             state_r, state_nxt;
  logic [STEP_W-1:0]      step_r, step_nxt;
  logic [DEN_W-1:0]       rem_r, rem_nxt;
  logic [DEN_W-1:0]       den_r, den_nxt;
  logic [QUOT_W-1:0]      quot_r, quot_nxt;
  logic                   neg_r, neg_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic                   out_valid_r, out_valid_nxt;
  cppi_result_t           out_r, out_nxt;

  logic [DEN_W:0]         rem_dbl;
  logic                   fits;
  logic [CORR_W-1:0]      mag_ext;
  logic                   out_free;

  assign job_ready  = (state_r == ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = out_r;
  assign out_free   = !out_valid_r || out_ready;

  // One restoring division step: shift the remainder, subtract if it fits.
  assign rem_dbl = {rem_r, 1'b0};
  assign fits    = rem_dbl >= {1'b0, den_r};
  assign mag_ext = CORR_W'(quot_r);

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    quot_nxt      = quot_r;
    neg_nxt       = neg_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    unique case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          rem_nxt   = DEN_W'(job.num_mag);
          den_nxt   = job.den_mag;
          neg_nxt   = job.negative;
          idx_nxt   = job.peak_index;
          quot_nxt  = '0;
          step_nxt  = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt  = fits ? DEN_W'(rem_dbl - {1'b0, den_r}) : rem_dbl[DEN_W-1:0];
        quot_nxt = {quot_r[QUOT_W-2:0], fits};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == LAST_STEP) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // Apply the sign and hand over once the output register is free.
        if (out_free) begin
          out_valid_nxt      = 1'b1;
          out_nxt.peak_index = idx_r;
          if (den_r == '0) begin
            out_nxt.correction = '0;
          end else begin
            out_nxt.correction = neg_r ? (~mag_ext + CORR_W'(1)) : mag_ext;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    quot_r <= quot_nxt;
    neg_r  <= neg_nxt;
    idx_r  <= idx_nxt;
    out_r  <= out_nxt;
  end

endmodule

// ===== rtl/circular_peak_pick_interp.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// in_       slave      in_tvalid/in_tready    in_tdata[15:0] = sample
// out_      master     out_tvalid/out_tready  out_tdata[11:0] = peak_index,
//                                             out_tdata[27:12] = correction
// cfg_      APB slave  psel/penable/pready    register 0 at byte 0: index_modulus
//
// A sample that is no peak is absorbed as soon as in_tready is high. A peak occupies the
// back end while it takes the job, runs the 14 steps of the restoring divider, and then
// signs the quotient and loads the output register once that register is free.
// A two-entry queue lets the front keep taking samples while the divider works;
// in_tready falls only when the queue is full.
// Reset is synchronous and active low; it clears the history, the index and the
// modulus (back to 1024). Configuration writes leave the history untouched.

module circular_peak_pick_interp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [cppi_pkg::IN_DATA_W-1:0]      in_tdata,   // [15:0] sample
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [cppi_pkg::OUT_DATA_W-1:0]     out_tdata,  // [11:0] peak_index,
                                                          // [27:12] correction
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [cppi_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [cppi_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [cppi_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);
  import cppi_pkg::*;

  logic [MOD_W-1:0] modulus_r, modulus_nxt;
  logic             cfg_write;
  logic             cfg_hit;
  logic             fq_valid, fq_ready;
  cppi_job_t        fq_job;
  logic             qb_valid, qb_ready;
  cppi_job_t        qb_job;
  cppi_result_t     result;

  // Configuration register.
  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[2] == CFG_IDX_MODULUS);
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = cfg_hit ? CFG_DATA_W'(modulus_r) : '0;

  always_comb begin
    modulus_nxt = modulus_r;
    if (cfg_write && cfg_hit) begin
      modulus_nxt = cfg_pwdata[MOD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MODULUS_RESET;
    end else begin
      modulus_r <= modulus_nxt;
    end
  end

  // Front end: history, index and peak test.
  cppi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .modulus   (modulus_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_sample (in_tdata[SAMPLE_BITS-1:0]),
    .job_valid (fq_valid),
    .job_ready (fq_ready),
    .job       (fq_job)
  );

  // Queue of peaks waiting for the divider.
  cppi_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_job   (fq_job),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_job    (qb_job)
  );

  // Back end: serial divider and output register.
  cppi_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (qb_valid),
    .job_ready  (qb_ready),
    .job        (qb_job),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (result)
  );

  assign out_tdata = OUT_DATA_W'(result);

endmodule

// ===== rtl/cppi_checker.sv =====
`timescale 1ns / 1ps

module cppi_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [cppi_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            cfg_pready
);
  import cppi_pkg::*;

  // A result waiting for the sink stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // The correction stays within one half sample.
  a_corr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[27:12]) <= 16'sd16384) &&
                   ($signed(out_tdata[27:12]) >= -16'sd16384))
    else $error("correction out of range");

  // Reset leaves no result on the output.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered right after reset");

  // The padding bits above the correction stay zero and the register port stays ready.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[31:28] == 4'd0) && cfg_pready)
    else $error("padding bits set or register port not ready");

endmodule

bind circular_peak_pick_interp cppi_checker u_cppi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_pready (cfg_pready)
);
